[hdl/prr_pkg.sv]
// prr_pkg: shared constants, types and helper functions of the polyphase resampler
// used by prr_ctrl, prr_dpath and polyphase_rational_resampler_unit
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

    localparam int NTAPS        = 32;
    localparam int MAX_RATE     = 16;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;

    localparam int TAP_W   = $clog2(NTAPS);
    localparam int PH_W    = $clog2(MAX_RATE);
    localparam int RATE_W  = 5;
    localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W   = PROD_W + TAP_W;
    localparam int CADDR_W = PH_W + TAP_W;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [0:0] REG_INTERP = 1'b0;
    localparam logic [0:0] REG_DECIM  = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef struct packed {
        logic             hist_wr;
        logic             coef_wr;
        logic             skip_dec;
        logic             mac_issue;
        logic             mac_clr;
        logic [TAP_W-1:0] tap;
        logic             step_init;
        logic             div_step;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic skip_nz;
        logic mac_busy;
        logic div_more;
        logic adv_nz;
        logic out_free;
    } t_sts;

    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] v);
        logic [RATE_W-1:0] r;
        if (v == '0) begin
            r = RATE_W'(1);
        end else if (v > RATE_W'(MAX_RATE)) begin
            r = RATE_W'(MAX_RATE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] sat_out(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0]          sh;
        logic [ACC_W-SAMPLE_WIDTH:0]      hi;
        logic [SAMPLE_WIDTH-1:0]          r;
        sh = a >>> (COEF_WIDTH - 1);
        hi = sh[ACC_W-1:SAMPLE_WIDTH-1];
        if ((&hi) || (~|hi)) begin
            r = sh[SAMPLE_WIDTH-1:0];
        end else if (sh[ACC_W-1]) begin
            r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/prr_ctrl.sv]
// prr_ctrl: sequencer of the resampler, issues history and coefficient writes, skips, tap reads,
// phase steps and output loads; depends on prr_pkg
`timescale 1ns / 1ps
`default_nettype none

module prr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_kind,
    output logic               o_in_ready,
    input  wire prr_pkg::t_sts i_sts,
    output prr_pkg::t_cmd      o_cmd
);
    import prr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_STEP,
        S_DIV,
        S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [TAP_W-1:0] r_tap, n_tap;
    logic             w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        o_cmd   = '0;
        o_cmd.tap = r_tap;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_in_kind == KIND_COEF) begin
                        o_cmd.coef_wr = 1'b1;
                    end else begin
                        o_cmd.hist_wr = 1'b1;
                        if (i_sts.skip_nz) begin
                            o_cmd.skip_dec = 1'b1;
                        end else begin
                            n_state = S_MAC;
                            n_tap   = '0;
                        end
                    end
                end
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                o_cmd.mac_clr   = (r_tap == '0);
                n_tap           = r_tap + TAP_W'(1);
                if (r_tap == TAP_W'(NTAPS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.mac_busy) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step_init = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_more) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.adv_nz) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_MAC;
                        n_tap   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

endmodule

`default_nettype wire

[hdl/prr_dpath.sv]
// prr_dpath: sample history, coefficient memory, complex mac, phase logic,
// ratio registers and output register; depends on prr_pkg
`timescale 1ns / 1ps
`default_nettype none

module prr_dpath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire prr_pkg::t_cmd                        i_cmd,
    output prr_pkg::t_sts                             o_sts,
    input  wire logic [prr_pkg::SAMPLE_WIDTH-1:0]     i_sample_i,
    input  wire logic [prr_pkg::SAMPLE_WIDTH-1:0]     i_sample_q,
    input  wire logic [prr_pkg::PH_W-1:0]             i_coef_phase,
    input  wire logic [prr_pkg::TAP_W-1:0]            i_coef_index,
    input  wire logic [prr_pkg::COEF_WIDTH-1:0]       i_coef_value,
    input  wire logic                                 i_cfg_wr,
    input  wire logic [0:0]                           i_cfg_idx,
    input  wire logic [prr_pkg::RATE_W-1:0]           i_cfg_data,
    output logic [prr_pkg::RATE_W-1:0]                o_interp,
    output logic [prr_pkg::RATE_W-1:0]                o_decim,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [prr_pkg::SAMPLE_WIDTH-1:0]          o_out_i,
    output logic [prr_pkg::SAMPLE_WIDTH-1:0]          o_out_q,
    output logic                                      o_out_last
);
    import prr_pkg::*;

    // history: circular buffer, write pointer points at the oldest entry
    logic [2*SAMPLE_WIDTH-1:0] r_hist_mem [NTAPS];
    logic [NTAPS-1:0]          r_hist_vld;
    logic [TAP_W-1:0]          r_wp;
    logic [TAP_W-1:0]          w_haddr;

    logic [COEF_WIDTH-1:0]     r_coef_mem [MAX_RATE*NTAPS];

    logic [2*SAMPLE_WIDTH-1:0] r_hrd;
    logic                      r_hrd_v;
    logic [COEF_WIDTH-1:0]     r_crd;
    logic                      r_s1, r_s2;

    logic signed [SAMPLE_WIDTH-1:0] w_hi, w_hq;
    logic signed [COEF_WIDTH-1:0]   w_c;
    logic signed [PROD_W-1:0]       r_prod_i, r_prod_q;
    logic signed [ACC_W-1:0]        r_acc_i, r_acc_q;

    logic [RATE_W-1:0] r_interp, r_decim;
    logic [PH_W-1:0]   r_phase;
    logic [RATE_W-1:0] r_sum;
    logic [RATE_W-1:0] r_adv;
    logic [RATE_W-1:0] r_skip;

    logic r_out_vld;

    assign w_haddr = r_wp + i_cmd.tap;

    // history and coefficient memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_wr) begin
            r_hist_mem[r_wp] <= {i_sample_q, i_sample_i};
        end
        if (i_cmd.coef_wr) begin
            r_coef_mem[{i_coef_phase, i_coef_index}] <= i_coef_value;
        end
        r_hrd <= r_hist_mem[w_haddr];
        r_crd <= r_coef_mem[{r_phase, i_cmd.tap}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
            r_wp       <= '0;
            r_hrd_v    <= 1'b0;
        end else begin
            r_hrd_v <= r_hist_vld[w_haddr];
            if (i_cmd.hist_wr) begin
                r_hist_vld[r_wp] <= 1'b1;
                r_wp             <= r_wp + TAP_W'(1);
            end
        end
    end

    // mac pipeline: read, multiply, accumulate
    assign w_hi = r_hrd_v ? r_hrd[SAMPLE_WIDTH-1:0] : '0;
    assign w_hq = r_hrd_v ? r_hrd[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] : '0;
    assign w_c  = r_crd;

    always_ff @(posedge i_clk) begin
        r_prod_i <= w_c * w_hi;
        r_prod_q <= w_c * w_hq;
        if (i_cmd.mac_clr) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_s2) begin
            r_acc_i <= r_acc_i + {{(ACC_W-PROD_W){r_prod_i[PROD_W-1]}}, r_prod_i};
            r_acc_q <= r_acc_q + {{(ACC_W-PROD_W){r_prod_q[PROD_W-1]}}, r_prod_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= 1'b0;
            r_s2 <= 1'b0;
        end else begin
            r_s1 <= i_cmd.mac_issue;
            r_s2 <= r_s1;
        end
    end

    // ratio registers, phase accumulator, skip counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp <= RATE_W'(1);
            r_decim  <= RATE_W'(1);
            r_phase  <= '0;
            r_skip   <= '0;
            r_sum    <= '0;
            r_adv    <= '0;
        end else begin
            if (i_cfg_wr) begin
                unique case (i_cfg_idx)
                    REG_INTERP: r_interp <= clamp_rate(i_cfg_data);
                    REG_DECIM:  r_decim  <= clamp_rate(i_cfg_data);
                    default:    r_interp <= r_interp;
                endcase
                r_phase <= '0;
                r_skip  <= '0;
            end else begin
                if (i_cmd.skip_dec) begin
                    r_skip <= r_skip - RATE_W'(1);
                end
                if (i_cmd.step_init) begin
                    r_sum <= RATE_W'(r_phase) + r_decim;
                    r_adv <= '0;
                end else if (i_cmd.div_step) begin
                    r_sum <= r_sum - r_interp;
                    r_adv <= r_adv + RATE_W'(1);
                end
                if (i_cmd.out_load) begin
                    r_phase <= r_sum[PH_W-1:0];
                    if (r_adv != '0) begin
                        r_skip <= r_adv - RATE_W'(1);
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_i    <= sat_out(r_acc_i);
            o_out_q    <= sat_out(r_acc_q);
            o_out_last <= (r_adv != '0);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_interp       = r_interp;
    assign o_decim        = r_decim;

    assign o_sts.skip_nz  = (r_skip != '0);
    assign o_sts.mac_busy = r_s1 || r_s2;
    assign o_sts.div_more = (r_sum >= r_interp);
    assign o_sts.adv_nz   = (r_adv != '0);
    assign o_sts.out_free = !r_out_vld || i_out_ready;

endmodule

`default_nettype wire

[hdl/polyphase_rational_resampler_unit.sv]
// polyphase_rational_resampler_unit: top level, stream and register ports
// depends on prr_pkg, prr_ctrl, prr_dpath
// order: a sample's tap reads pass the mac pipeline, then the drain, the phase step and the
// division steps; each output takes one mac per tap on the shared multiplier pair
// a coefficient load or a skipped sample is taken without leaving the idle state
// reset: synchronous active low, clears history, phase, skip count and ratios to 1
`timescale 1ns / 1ps
`default_nettype none

module polyphase_rational_resampler_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // sample_i, sample_q, coef_phase, coef_index, coef_value, zero pad
    input  wire logic [prr_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_i, out_q
    output logic [prr_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [prr_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [prr_pkg::PDATA_W-1:0]       pwdata,
    output logic [prr_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready
);
    import prr_pkg::*;

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [RATE_W-1:0] w_interp, w_decim;
    logic [SAMPLE_WIDTH-1:0] w_out_i, w_out_q;
    logic              w_cfg_wr;
    logic [0:0]        w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[2];

    always_comb begin
        unique case (w_cfg_idx)
            REG_INTERP: prdata = PDATA_W'(w_interp);
            REG_DECIM:  prdata = PDATA_W'(w_decim);
            default:    prdata = '0;
        endcase
    end

    prr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_in_kind  (s_tuser),
        .o_in_ready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    prr_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_sample_i   (s_tdata[15:0]),
        .i_sample_q   (s_tdata[31:16]),
        .i_coef_phase (s_tdata[35:32]),
        .i_coef_index (s_tdata[40:36]),
        .i_coef_value (s_tdata[56:41]),
        .i_cfg_wr     (w_cfg_wr),
        .i_cfg_idx    (w_cfg_idx),
        .i_cfg_data   (pwdata[RATE_W-1:0]),
        .o_interp     (w_interp),
        .o_decim      (w_decim),
        .o_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .o_out_i      (w_out_i),
        .o_out_q      (w_out_q),
        .o_out_last   (m_tlast)
    );

    assign m_tdata = {w_out_q, w_out_i};

endmodule

`default_nettype wire

[hdl/prr_chk.sv]
// prr_chk: port-level checks of the resampler top level, with bind
// depends on polyphase_rational_resampler_unit
`timescale 1ns / 1ps
`default_nettype none

module prr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        pready
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("held output changed");

    // coefficient loads never stall the input
    a_coef_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser |=> s_tready)
        else $error("input stalled after coefficient load");

    // a new result cannot appear right after a sample request
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && !s_tuser |=> !$rose(m_tvalid))
        else $error("output appeared too early");

    // output register empty after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind polyphase_rational_resampler_unit prr_chk u_prr_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

`default_nettype wire

[tb/polyphase_rational_resampler_unit_test.sv]
// self-checking testbench for polyphase_rational_resampler_unit: streams coefficient loads,
// ratio writes and complex samples, predicts every resampled output and checks it; uses prr_pkg
`timescale 1ns / 1ps

module polyphase_rational_resampler_unit_test;
    import prr_pkg::*;

    localparam int TAIL_CYCLES = 48;

    // sample_i, sample_q, coef_phase, coef_index, coef_value, zero pad
    typedef struct packed {
        logic [6:0]         pad;
        logic signed [15:0] coef_value;
        logic [4:0]         coef_index;
        logic [3:0]         coef_phase;
        logic signed [15:0] sample_q;
        logic signed [15:0] sample_i;
    } req_word_t;

    typedef struct packed {
        logic signed [15:0] out_q;
        logic signed [15:0] out_i;
    } out_word_t;

    typedef struct packed {
        logic               last;
        logic signed [15:0] im;
        logic signed [15:0] re;
    } out_expect_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tlast;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    // predictor state
    logic signed [15:0] hist_re [NTAPS];
    logic signed [15:0] hist_im [NTAPS];
    logic signed [15:0] tap_bank [MAX_RATE][NTAPS];
    int                 phase_acc_m;
    int                 skip_left;
    int                 interp_m;
    int                 decim_m;

    out_expect_t resample_queue [$];

    bit idling;
    int error_count;
    int outputs_checked;
    int samples_sent;
    int coef_loads;
    int ratio_settings;

    polyphase_rational_resampler_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    initial begin
        #20_000_000;
        $display("polyphase_rational_resampler_unit_test: FAIL");
        $finish;
    end

    function automatic int rate_of(input logic [4:0] raw);
        if (raw == 5'd0) begin
            return 1;
        end
        if (raw > 5'(MAX_RATE)) begin
            return MAX_RATE;
        end
        return int'(raw);
    endfunction

    function automatic logic signed [15:0] floor_sat(input longint acc);
        longint v;
        v = acc >>> (COEF_WIDTH - 1);
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    function automatic void resample_sample(input logic signed [15:0] si,
                                            input logic signed [15:0] sq);
        longint      acc_re;
        longint      acc_im;
        int          t;
        int          n;
        int          adv;
        out_expect_t e;
        for (t = 0; t < NTAPS - 1; t++) begin
            hist_re[t] = hist_re[t+1];
            hist_im[t] = hist_im[t+1];
        end
        hist_re[NTAPS-1] = si;
        hist_im[NTAPS-1] = sq;
        if (skip_left != 0) begin
            skip_left--;
            return;
        end
        n = 0;
        while (n < MAX_RATE) begin
            acc_re = 0;
            acc_im = 0;
            for (t = 0; t < NTAPS; t++) begin
                acc_re += longint'(tap_bank[phase_acc_m][t]) * longint'(hist_re[t]);
                acc_im += longint'(tap_bank[phase_acc_m][t]) * longint'(hist_im[t]);
            end
            e.re   = floor_sat(acc_re);
            e.im   = floor_sat(acc_im);
            e.last = 1'b0;
            n++;
            phase_acc_m += decim_m;
            adv = phase_acc_m / interp_m;
            phase_acc_m = phase_acc_m % interp_m;
            if (adv != 0) begin
                skip_left = adv - 1;
                e.last    = 1'b1;
            end else if (n == MAX_RATE) begin
                e.last = 1'b1;
            end
            resample_queue.push_back(e);
            if (e.last) begin
                break;
            end
        end
    endfunction

    function automatic req_word_t sample_word(input logic signed [15:0] si,
                                              input logic signed [15:0] sq);
        req_word_t w;
        w            = {$urandom, $urandom};
        w.pad        = '0;
        w.sample_i   = si;
        w.sample_q   = sq;
        return w;
    endfunction

    function automatic req_word_t coef_word(input logic [3:0] ph, input logic [4:0] ix,
                                            input logic signed [15:0] val);
        req_word_t w;
        w            = {$urandom, $urandom};
        w.pad        = '0;
        w.coef_phase = ph;
        w.coef_index = ix;
        w.coef_value = val;
        return w;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        if ($urandom_range(0, 1) == 0) begin
            return 16'($urandom);
        end
        return 16'($signed($urandom_range(0, 1023)) - 512);
    endfunction

    task automatic send_item(input logic kind, input req_word_t w);
        if (idling && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= kind;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        if (kind == KIND_COEF) begin
            tap_bank[w.coef_phase][w.coef_index] = w.coef_value;
            coef_loads++;
        end else begin
            resample_sample(w.sample_i, w.sample_q);
            samples_sent++;
        end
    endtask

    task automatic stream_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        stream_idle();
        while (resample_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [0:0] idx, input logic [4:0] raw);
        logic [PDATA_W-1:0] word;
        word      = $urandom;
        word[4:0] = raw;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (idx == REG_INTERP) begin
            interp_m = rate_of(raw);
        end else begin
            decim_m = rate_of(raw);
        end
        phase_acc_m = 0;
        skip_left   = 0;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_ratio(input logic [4:0] interp_raw, input logic [4:0] decim_raw);
        wait_idle();
        apb_write(REG_INTERP, interp_raw);
        apb_write(REG_DECIM, decim_raw);
        ratio_settings++;
    endtask

    // branch 0 gets small taps and two full-scale newest taps, the rest is random
    task automatic test_coef_fill();
        int                 ph;
        int                 ix;
        logic signed [15:0] val;
        for (ph = 0; ph < MAX_RATE; ph++) begin
            for (ix = 0; ix < NTAPS; ix++) begin
                if (ph == 0 && ix >= NTAPS - 2) begin
                    val = -16'sd32768;
                end else if (ph == 0) begin
                    val = 16'($signed($urandom_range(0, 128)) - 64);
                end else begin
                    val = 16'($urandom);
                end
                send_item(KIND_COEF, coef_word(4'(ph), 5'(ix), val));
            end
        end
    endtask

    task automatic test_saturation_and_extremes();
        send_item(KIND_SAMPLE, sample_word(-16'sd32768, 16'sd32767));
        send_item(KIND_SAMPLE, sample_word(-16'sd32768, 16'sd32767));
        send_item(KIND_SAMPLE, sample_word(16'sd32767, -16'sd32768));
        send_item(KIND_SAMPLE, sample_word(16'sd32767, -16'sd32768));
        send_item(KIND_COEF, coef_word(4'd15, 5'd31, 16'sd32767));
        send_item(KIND_COEF, coef_word(4'd15, 5'd0, -16'sd32768));
        send_item(KIND_COEF, coef_word(4'd0, 5'd0, 16'sd32767));
        send_item(KIND_SAMPLE, sample_word(-16'sd1, -16'sd1));
        send_item(KIND_SAMPLE, sample_word(16'sd1, 16'sd0));
        send_item(KIND_SAMPLE, sample_word(16'sd0, 16'sd0));
    endtask

    // interpolation 16, decimation 0 acting as 1: longest run of outputs per sample
    task automatic test_longest_run();
        program_ratio(5'd16, 5'd0);
        repeat (2) send_item(KIND_SAMPLE, sample_word(rand_sample(), rand_sample()));
    endtask

    // interpolation 0 acting as 1, decimation 31 acting as 16: fifteen skipped samples
    task automatic test_skipped_samples();
        program_ratio(5'd0, 5'd31);
        repeat (18) send_item(KIND_SAMPLE, sample_word(rand_sample(), rand_sample()));
    endtask

    task automatic test_random_ratios();
        int         p;
        int         k;
        logic [4:0] ri;
        logic [4:0] rd;
        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    ri = 5'd16;
                    rd = 5'd16;
                end
                1: begin
                    ri = 5'd1;
                    rd = 5'd1;
                end
                2: begin
                    ri = 5'd3;
                    rd = 5'd2;
                end
                default: begin
                    ri = 5'($urandom_range(0, 31));
                    rd = 5'($urandom_range(0, 31));
                end
            endcase
            program_ratio(ri, rd);
            idling = (p < 7);
            for (k = 0; k < 50; k++) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_item(KIND_COEF, coef_word(4'($urandom_range(0, 15)),
                        5'($urandom_range(0, 31)), 16'($urandom)));
                end else begin
                    send_item(KIND_SAMPLE, sample_word(rand_sample(), rand_sample()));
                end
            end
        end
    endtask

    // downstream back-pressure
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall = $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_outputs
        out_word_t   got;
        out_expect_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (resample_queue.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual i=%0d q=%0d last=%0b",
                    $time, got.out_i, got.out_q, m_tlast);
                error_count++;
            end else begin
                want = resample_queue.pop_front();
                if (got.out_i !== want.re) begin
                    $display("%0t: out_i mismatch, expected %0d, actual %0d",
                        $time, want.re, got.out_i);
                    error_count++;
                end
                if (got.out_q !== want.im) begin
                    $display("%0t: out_q mismatch, expected %0d, actual %0d",
                        $time, want.im, got.out_q);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                        $time, want.last, m_tlast);
                    error_count++;
                end
                outputs_checked++;
            end
        end
    end

    initial begin
        int t;
        i_rst_n         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = KIND_SAMPLE;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        idling          = 1'b1;
        error_count     = 0;
        outputs_checked = 0;
        samples_sent    = 0;
        coef_loads      = 0;
        ratio_settings  = 0;
        for (t = 0; t < NTAPS; t++) begin
            hist_re[t] = '0;
            hist_im[t] = '0;
        end
        phase_acc_m = 0;
        skip_left   = 0;
        interp_m    = 1;
        decim_m     = 1;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_coef_fill();
        test_saturation_and_extremes();
        test_longest_run();
        test_skipped_samples();
        test_random_ratios();
        wait_idle();

        $display("covered %0d samples and %0d coefficient loads under %0d ratio settings",
            samples_sent, coef_loads, ratio_settings);
        $display("checked %0d resampled outputs, %0d mismatches", outputs_checked, error_count);
        if (error_count == 0) begin
            $display("polyphase_rational_resampler_unit_test: PASS");
        end else begin
            $display("polyphase_rational_resampler_unit_test: FAIL");
        end
        $finish;
    end

endmodule
